/* rtl/lspo_pkg.sv */
// Shared types and constants for the looped sample-playback oscillator.
// No dependencies; imported by the unit and by its checker.
`default_nettype none

package lspo_pkg;

    localparam int DEFAULT_SAMPLE_DEPTH  = 65536;
    localparam int DEFAULT_FRACTION_BITS = 16;

    localparam int PHASE_W   = 32;
    localparam int SAMPLE_W  = 16;
    localparam int ADDR_W    = 16;
    localparam int INC_W     = 24;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    localparam logic [INC_W-1:0]  RST_PHASE_INC = 24'd65536;
    localparam logic [ADDR_W-1:0] RST_START     = 16'd0;
    localparam logic [ADDR_W-1:0] RST_LOOP      = 16'd0;
    localparam logic [ADDR_W-1:0] RST_END       = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_KEY_ON = 2'd1,
        KIND_TICK   = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC = 3'd0,
        CFG_START     = 3'd1,
        CFG_LOOP      = 3'd2,
        CFG_END       = 3'd3,
        CFG_LOOP_MODE = 3'd4
    } t_cfg_index;

endpackage

`default_nettype wire

/* rtl/looped_sample_playback_osc_unit.sv */
// A tick word is registered in the tap and blend stage, then in the output register.
// Throughput: one input word per cycle unless a stalled output holds the blend stage,
// any mix of writes, key-ons and ticks; a tick reads memory at both taps as it is accepted.
// Config writes are taken in every cycle and act from the next word on.
// Reset clears phase, voice state and all valid flags, sets config registers to defaults;
// the sample memory is not cleared and holds garbage until written.
`default_nettype none

module looped_sample_playback_osc_unit #(
    parameter int SAMPLE_DEPTH  = lspo_pkg::DEFAULT_SAMPLE_DEPTH,
    parameter int FRACTION_BITS = lspo_pkg::DEFAULT_FRACTION_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire logic [lspo_pkg::KIND_W-1:0]           i_kind,
    input  wire logic [lspo_pkg::ADDR_W-1:0]           i_address,
    input  wire logic signed [lspo_pkg::SAMPLE_W-1:0]  i_sample_word,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic signed [lspo_pkg::SAMPLE_W-1:0]       o_audio_out,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [lspo_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [lspo_pkg::CFG_W-1:0]            i_cfg_data
);
    import lspo_pkg::*;

    localparam int MEM_AW = $clog2(SAMPLE_DEPTH);
    localparam int IDX_W  = PHASE_W - FRACTION_BITS;
    localparam int CMP_W  = IDX_W + 1;
    localparam int PROD_W = SAMPLE_W + FRACTION_BITS + 2;
    localparam int SUM_W  = PROD_W + 1;

    // config registers
    logic [INC_W-1:0]  r_phase_inc;
    logic [ADDR_W-1:0] r_start;
    logic [ADDR_W-1:0] r_loop;
    logic [ADDR_W-1:0] r_end;
    logic              r_loop_mode;

    // voice state
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic               r_active;

    // sample memory and tap read registers
    logic signed [SAMPLE_W-1:0] r_mem [SAMPLE_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_a;
    logic signed [SAMPLE_W-1:0] r_rd_b;

    // blend stage and output register
    logic                       r_s1_valid;
    logic                       r_s1_active;
    logic [FRACTION_BITS-1:0]   r_s1_frac;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_audio;

    logic w_accept, w_wr, w_key_on, w_tick, w_out_free;
    logic [IDX_W-1:0]   w_idx_a;
    logic [CMP_W-1:0]   w_idx_b;
    logic [CMP_W-1:0]   w_end_c;
    logic [CMP_W-1:0]   w_lim_c;
    logic [CMP_W-1:0]   w_tap_a;
    logic [CMP_W-1:0]   w_tap_b;
    logic [ADDR_W-1:0]  w_lim;
    logic [31:0]        w_tap_a32;
    logic [31:0]        w_tap_b32;
    logic [31:0]        w_wr_a32;
    logic [MEM_AW-1:0]  w_addr_a;
    logic [MEM_AW-1:0]  w_addr_b;
    logic [MEM_AW-1:0]  w_addr_wr;
    logic [PHASE_W:0]   w_sum;
    logic [PHASE_W-1:0] w_loop_base;
    logic [PHASE_W-1:0] w_end_next;
    logic [PHASE_W-1:0] w_step;

    logic signed [SAMPLE_W:0]  w_diff;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [SUM_W-1:0]   w_blend_sum;

    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || w_out_free;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_wr        = w_accept && (i_kind == KIND_WRITE);
    assign w_key_on    = w_accept && (i_kind == KIND_KEY_ON);
    assign w_tick      = w_accept && (i_kind == KIND_TICK);

    // tap selection
    always_comb begin
        w_idx_a = r_phase[PHASE_W-1:FRACTION_BITS];
        w_idx_b = CMP_W'(w_idx_a) + CMP_W'(1);
        w_end_c = CMP_W'(r_end);
        w_lim   = (r_end != '0) ? r_end - ADDR_W'(1) : '0;
        w_lim_c = CMP_W'(w_lim);
        if (r_loop_mode) begin
            w_tap_a = CMP_W'(w_idx_a);
            w_tap_b = (w_idx_b > w_end_c) ? CMP_W'(r_loop) : w_idx_b;
        end else begin
            w_tap_a = (CMP_W'(w_idx_a) > w_lim_c) ? w_lim_c : CMP_W'(w_idx_a);
            w_tap_b = (w_idx_b > w_lim_c) ? w_lim_c : w_idx_b;
        end
        // indexes wrap modulo the memory depth rounded up to a power of two
        w_tap_a32 = 32'(w_tap_a);
        w_tap_b32 = 32'(w_tap_b);
        w_wr_a32  = 32'(i_address);
        w_addr_a  = w_tap_a32[MEM_AW-1:0];
        w_addr_b  = w_tap_b32[MEM_AW-1:0];
        w_addr_wr = w_wr_a32[MEM_AW-1:0];
    end

    // phase advance
    always_comb begin
        w_sum       = (PHASE_W+1)'(r_phase) + (PHASE_W+1)'(r_phase_inc);
        w_loop_base = PHASE_W'(r_loop) << FRACTION_BITS;
        w_end_next  = (PHASE_W'(r_end) + PHASE_W'(1)) << FRACTION_BITS;
        if (r_loop_mode) begin
            if ((w_sum >> FRACTION_BITS) > (PHASE_W+1)'(r_end)) begin
                // keep the overshoot past the end
                w_step = w_sum[PHASE_W-1:0] - w_end_next + w_loop_base;
            end else begin
                w_step = w_sum[PHASE_W-1:0];
            end
        end else begin
            w_step = w_sum[PHASE_W] ? '1 : w_sum[PHASE_W-1:0];
        end
        n_phase = r_phase;
        if (w_key_on) begin
            n_phase = PHASE_W'(r_start) << FRACTION_BITS;
        end else if (w_tick && r_active) begin
            n_phase = w_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= RST_PHASE_INC;
            r_start     <= RST_START;
            r_loop      <= RST_LOOP;
            r_end       <= RST_END;
            r_loop_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PHASE_INC: r_phase_inc <= i_cfg_data[INC_W-1:0];
                CFG_START:     r_start     <= i_cfg_data[ADDR_W-1:0];
                CFG_LOOP:      r_loop      <= i_cfg_data[ADDR_W-1:0];
                CFG_END:       r_end       <= i_cfg_data[ADDR_W-1:0];
                CFG_LOOP_MODE: r_loop_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_active <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_key_on) begin
                r_active <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_addr_wr] <= i_sample_word;
        end
        if (w_tick) begin
            r_rd_a <= r_mem[w_addr_a];
            r_rd_b <= r_mem[w_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_s1_active <= r_active;
            r_s1_frac   <= r_phase[FRACTION_BITS-1:0];
        end
    end

    // out = (a << fb) + (b - a) * frac + half, floored
    always_comb begin
        w_diff      = (SAMPLE_W+1)'(r_rd_b) - (SAMPLE_W+1)'(r_rd_a);
        w_prod      = PROD_W'(w_diff) * $signed(PROD_W'(r_s1_frac));
        w_blend_sum = (SUM_W'(r_rd_a) <<< FRACTION_BITS) + SUM_W'(w_prod)
                    + (SUM_W'(1) << (FRACTION_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= w_tick;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r_s1_valid) begin
            r_audio <= r_s1_active ? w_blend_sum[FRACTION_BITS +: SAMPLE_W] : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_audio_out = r_audio;

endmodule

`default_nettype wire

/* rtl/lspo_checker.sv */
// Port-level checks for the looped sample-playback oscillator.
// Depends on lspo_pkg; bound to looped_sample_playback_osc_unit below.
`default_nettype none

module lspo_checker (
    input wire logic                                  i_clk,
    input wire logic                                  i_rst_n,
    input wire logic                                  i_in_valid,
    input wire logic                                  o_in_ready,
    input wire logic [lspo_pkg::KIND_W-1:0]           i_kind,
    input wire logic [lspo_pkg::ADDR_W-1:0]           i_address,
    input wire logic signed [lspo_pkg::SAMPLE_W-1:0]  i_sample_word,
    input wire logic                                  o_out_valid,
    input wire logic                                  i_out_ready,
    input wire logic signed [lspo_pkg::SAMPLE_W-1:0]  o_audio_out,
    input wire logic                                  i_cfg_valid,
    input wire logic                                  o_cfg_ready,
    input wire logic [lspo_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input wire logic [lspo_pkg::CFG_W-1:0]            i_cfg_data
);
    import lspo_pkg::*;

    logic w_tick_in;
    assign w_tick_in = i_in_valid && o_in_ready && (i_kind == KIND_TICK);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_audio_out))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // a fresh output word comes from a tick that passed the blend stage and output register
    a_rose_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_tick_in, 2))
        else $error("output word without a tick");

    // a ready sink never stalls the input side
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready && o_cfg_ready)
        else $error("input stalled with ready sink");

endmodule

bind looped_sample_playback_osc_unit lspo_checker u_lspo_checker (.*);

`default_nettype wire

/* verif/lspo_playback_checker.sv */
// Checker for the looped sample-playback oscillator: watches the input, output and
// config channels, predicts every audio word and compares it. Depends on lspo_pkg.
`timescale 1ns / 100ps

module lspo_playback_checker (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    input  wire logic                                  i_in_ready,
    input  wire logic [lspo_pkg::KIND_W-1:0]           i_kind,
    input  wire logic [lspo_pkg::ADDR_W-1:0]           i_address,
    input  wire logic signed [lspo_pkg::SAMPLE_W-1:0]  i_sample_word,
    input  wire logic                                  i_out_valid,
    input  wire logic                                  i_out_ready,
    input  wire logic signed [lspo_pkg::SAMPLE_W-1:0]  i_audio_out,
    input  wire logic                                  i_cfg_valid,
    input  wire logic                                  i_cfg_ready,
    input  wire logic [lspo_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [lspo_pkg::CFG_W-1:0]            i_cfg_data,
    output int                                         o_fail_count,
    output int                                         o_pending
);
    import lspo_pkg::*;

    localparam int    FB       = DEFAULT_FRACTION_BITS;
    localparam longint UNITY   = longint'(1) << FB;

    logic signed [SAMPLE_W-1:0] sample_mem [DEFAULT_SAMPLE_DEPTH];
    logic [PHASE_W-1:0]         phase_acc;
    logic                       voice_on;
    logic [INC_W-1:0]           step_reg;
    logic [ADDR_W-1:0]          start_reg;
    logic [ADDR_W-1:0]          loop_reg;
    logic [ADDR_W-1:0]          end_reg;
    logic                       loop_on;
    logic signed [SAMPLE_W-1:0] audio_queue [$];
    int                         fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                   input logic [SAMPLE_W-1:0] got);
        $display("%0t ns: %s: expected %0d, got %0d", $time, what, $signed(want),
                 $signed(got));
        fail_count++;
    endtask

    // Blend the two taps next to ph and work out the phase that follows it.
    function automatic logic signed [SAMPLE_W-1:0] interpolate(
        input  logic [PHASE_W-1:0] ph,
        output logic [PHASE_W-1:0] ph_next
    );
        logic [PHASE_W+1:0] sum_ph;
        logic [PHASE_W+1:0] over;
        logic [ADDR_W:0]    tap_a;
        logic [ADDR_W:0]    tap_b;
        logic [ADDR_W:0]    tap_lim;
        longint             a;
        longint             b;
        longint             frac;
        longint             mix;
        sum_ph = {2'b00, ph} + (PHASE_W+2)'(step_reg);
        tap_a  = {1'b0, ph[PHASE_W-1:FB]};
        tap_b  = tap_a + 1'b1;
        frac   = longint'(ph[FB-1:0]);
        if (loop_on) begin
            // wrap past the end, keep the overshoot
            if (sum_ph[PHASE_W+1:FB] > (PHASE_W+2-FB)'(end_reg)) begin
                over   = sum_ph - {(PHASE_W+2-FB)'(end_reg) + 1'b1, FB'(0)};
                sum_ph = {2'b00, loop_reg, FB'(0)} + over;
            end
            if (tap_b > (ADDR_W+1)'(end_reg)) begin
                tap_b = (ADDR_W+1)'(loop_reg);
            end
            ph_next = sum_ph[PHASE_W-1:0];
        end else begin
            tap_lim = (end_reg != '0) ? (ADDR_W+1)'(end_reg) - 1'b1 : '0;
            if (tap_a > tap_lim) begin
                tap_a = tap_lim;
            end
            if (tap_b > tap_lim) begin
                tap_b = tap_lim;
            end
            ph_next = sum_ph[PHASE_W] ? '1 : sum_ph[PHASE_W-1:0];
        end
        a   = longint'(sample_mem[tap_a[ADDR_W-1:0]]);
        b   = longint'(sample_mem[tap_b[ADDR_W-1:0]]);
        mix = a * (UNITY - frac) + b * frac + (UNITY >>> 1);
        return SAMPLE_W'(mix >>> FB);
    endfunction

    always @(posedge i_clk) begin : watch
        logic signed [SAMPLE_W-1:0] want;
        logic [PHASE_W-1:0]         ph_next;
        if (!i_rst_n) begin
            phase_acc = '0;
            voice_on  = 1'b0;
            step_reg  = RST_PHASE_INC;
            start_reg = RST_START;
            loop_reg  = RST_LOOP;
            end_reg   = RST_END;
            loop_on   = 1'b0;
            audio_queue.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (audio_queue.size() == 0) begin
                    report_mismatch("audio word with nothing expected", '0, i_audio_out);
                end else begin
                    want = audio_queue.pop_front();
                    if (want !== i_audio_out) begin
                        report_mismatch("audio_out", want, i_audio_out);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PHASE_INC: step_reg  = i_cfg_data[INC_W-1:0];
                    CFG_START:     start_reg = i_cfg_data[ADDR_W-1:0];
                    CFG_LOOP:      loop_reg  = i_cfg_data[ADDR_W-1:0];
                    CFG_END:       end_reg   = i_cfg_data[ADDR_W-1:0];
                    CFG_LOOP_MODE: loop_on   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                case (i_kind)
                    KIND_WRITE: sample_mem[i_address] = i_sample_word;
                    KIND_KEY_ON: begin
                        phase_acc = {start_reg, FB'(0)};
                        voice_on  = 1'b1;
                    end
                    KIND_TICK: begin
                        if (!voice_on) begin
                            audio_queue.push_back('0);
                        end else begin
                            want      = interpolate(phase_acc, ph_next);
                            phase_acc = ph_next;
                            audio_queue.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= audio_queue.size();
    end

endmodule

/* verif/tb_looped_sample_playback_osc_unit.sv */
// Top of the oscillator testbench: drives writes, key-ons, ticks and config words
// into the unit and gives the verdict. Depends on lspo_pkg and lspo_playback_checker.
`timescale 1ns / 100ps

module tb_looped_sample_playback_osc_unit;
    import lspo_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int WINDOW      = 320;
    localparam int HIGH_BASE   = 65536 - WINDOW;
    localparam int CYCLE_LIMIT = 200000;

    logic                       clk;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic [KIND_W-1:0]          kind        = KIND_TICK;
    logic [ADDR_W-1:0]          address     = '0;
    logic signed [SAMPLE_W-1:0] sample_word = '0;
    logic                       out_ready   = 1'b0;
    logic                       cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index   = CFG_PHASE_INC;
    logic [CFG_W-1:0]           cfg_data    = '0;
    logic                       in_ready;
    logic                       out_valid;
    logic signed [SAMPLE_W-1:0] audio_out;
    logic                       cfg_ready;
    int                         fail_count;
    int                         pending;
    int                         snd_idle_pct = 0;
    int                         rcv_idle_pct = 0;
    int                         hold_left    = 0;
    int                         cycle_count  = 0;

    looped_sample_playback_osc_unit uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_kind        (kind),
        .i_address     (address),
        .i_sample_word (sample_word),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_audio_out   (audio_out),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    lspo_playback_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_kind        (kind),
        .i_address     (address),
        .i_sample_word (sample_word),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_audio_out   (audio_out),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_looped_sample_playback_osc_unit failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    task automatic send_word(input logic [KIND_W-1:0] k, input logic [ADDR_W-1:0] a,
                             input logic [SAMPLE_W-1:0] w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        address     <= a;
        sample_word <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop valid, wait out every pending audio word and the pipeline behind it.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_settings(input logic [INC_W-1:0] inc, input logic [ADDR_W-1:0] st,
                                 input logic [ADDR_W-1:0] lp, input logic [ADDR_W-1:0] ea,
                                 input logic mode);
        drain();
        write_reg(CFG_PHASE_INC, CFG_W'(inc));
        write_reg(CFG_START, CFG_W'(st));
        write_reg(CFG_LOOP, CFG_W'(lp));
        write_reg(CFG_END, CFG_W'(ea));
        write_reg(CFG_LOOP_MODE, CFG_W'(mode));
        cfg_valid <= 1'b0;
    endtask

    // Keep every tap inside one preloaded window: in loop mode the step may not
    // exceed the loop span, in one-shot mode the clamp keeps taps below the end.
    task automatic random_settings();
        int   base;
        int   st;
        int   lp;
        int   ea;
        int   inc_cap;
        int   inc;
        logic mode;
        base = $urandom_range(1) ? HIGH_BASE : 0;
        mode = 1'($urandom_range(1));
        st   = base + $urandom_range(WINDOW - 1);
        if (mode) begin
            lp      = base + $urandom_range(WINDOW - 1);
            ea      = $urandom_range(base + WINDOW - 1, lp);
            inc_cap = (ea - lp + 1) * 65536 - 1;
            if (inc_cap > 24'hFFFFFF) inc_cap = 24'hFFFFFF;
        end else begin
            lp      = $urandom_range(16'hFFFF);
            ea      = base + $urandom_range(WINDOW - 1, (base == 0) ? 0 : 1);
            inc_cap = 24'hFFFFFF;
        end
        case ($urandom_range(3))
            0:       inc = $urandom_range(inc_cap);
            1:       inc = inc_cap;
            default: inc = $urandom_range((inc_cap < 24'h3FFFF) ? inc_cap : 24'h3FFFF);
        endcase
        load_settings(INC_W'(inc), ADDR_W'(st), ADDR_W'(lp), ADDR_W'(ea), mode);
    endtask

    task automatic random_word();
        int r;
        r = $urandom_range(99);
        if (r < 55) begin
            send_word(KIND_TICK, ADDR_W'($urandom), SAMPLE_W'($urandom));
        end else if (r < 80) begin
            send_word(KIND_WRITE, ADDR_W'($urandom), SAMPLE_W'($urandom));
        end else if (r < 95) begin
            send_word(KIND_KEY_ON, ADDR_W'($urandom), SAMPLE_W'($urandom));
        end else begin
            send_word(KIND_UNUSED, ADDR_W'($urandom), SAMPLE_W'($urandom));
        end
    endtask

    initial begin
        int p;
        int s;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // voice still off: ticks give zero, the unused kind changes nothing
        send_word(KIND_TICK, '0, '0);
        send_word(KIND_UNUSED, 16'hFFFF, 16'h7FFF);

        // preload both tap windows before any voice starts
        for (int i = 0; i < WINDOW; i++) begin
            send_word(KIND_WRITE, ADDR_W'(i), SAMPLE_W'($urandom));
            send_word(KIND_WRITE, ADDR_W'(HIGH_BASE + i), SAMPLE_W'($urandom));
        end
        send_word(KIND_WRITE, 16'h0000, 16'h7FFF);
        send_word(KIND_WRITE, 16'h0001, 16'h8000);
        send_word(KIND_WRITE, 16'hFFFF, 16'h8000);
        send_word(KIND_WRITE, 16'hFFFE, 16'h7FFF);

        // one-shot with end at zero: both taps clamp to index zero
        load_settings(24'h008000, 16'd0, 16'd0, 16'd0, 1'b0);
        send_word(KIND_KEY_ON, '0, '0);
        send_word(KIND_TICK, '0, '0);
        send_word(KIND_TICK, '0, '0);

        // one-shot at the top with the largest step: clamp and saturate
        load_settings(24'hFFFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 1'b0);
        send_word(KIND_KEY_ON, '0, '0);
        repeat (4) send_word(KIND_TICK, '0, '0);

        // forward loop starting beyond the end, then restart while active
        load_settings(24'h028000, 16'd9, 16'd2, 16'd5, 1'b1);
        send_word(KIND_KEY_ON, '0, '0);
        repeat (4) send_word(KIND_TICK, '0, '0);
        send_word(KIND_KEY_ON, '0, '0);
        repeat (2) send_word(KIND_TICK, '0, '0);

        // zero step: phase holds
        load_settings(24'h000000, 16'd300, 16'd0, 16'd310, 1'b1);
        send_word(KIND_KEY_ON, '0, '0);
        repeat (2) send_word(KIND_TICK, '0, '0);

        for (p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    snd_idle_pct = 8;
                    rcv_idle_pct = 71;
                end
                1: begin
                    snd_idle_pct = 71;
                    rcv_idle_pct = 8;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            for (s = 0; s < 4; s++) begin
                random_settings();
                // hold the receiver off long enough to back up the input
                if (p == 2 && s == 1) hold_left = 300;
                send_word(KIND_KEY_ON, ADDR_W'($urandom), SAMPLE_W'($urandom));
                repeat (44) random_word();
            end
        end

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("tb_looped_sample_playback_osc_unit passed");
        end else begin
            $display("tb_looped_sample_playback_osc_unit failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/lspo_pkg.sv
rtl/looped_sample_playback_osc_unit.sv
rtl/lspo_checker.sv
verif/lspo_playback_checker.sv
verif/tb_looped_sample_playback_osc_unit.sv
